// ----- rtl/jsu_pkg.sv -----
`default_nettype none

package jsu_pkg;

  localparam int INQ_DEPTH  = 4;
  localparam int INQ_AW     = $clog2(INQ_DEPTH);
  localparam int RQ_DEPTH   = 4;
  localparam int RQ_AW      = $clog2(RQ_DEPTH);
  localparam int HIST_DEPTH = 8;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = 4;
  localparam int CP_W       = 21;

  localparam logic [CNT_W-1:0] HOLD_BS   = 4'd4;
  localparam logic [CNT_W-1:0] HOLD_U    = 4'd5;
  localparam logic [CNT_W-1:0] HOLD_LO0  = 4'd6;
  localparam logic [CNT_W-1:0] HOLD_LAST = 4'd9;
  localparam logic [CNT_W-1:0] HOLD_FULL = 4'd10;
  localparam logic [CNT_W-1:0] HEX_LAST  = 4'd3;
  localparam logic [CNT_W-1:0] HEX_FULL  = 4'd4;

  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h10000;
  localparam logic [CP_W-1:0] CP_REPLACE   = 21'h0FFFD;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0C;
  localparam logic [7:0] CTL_LF    = 8'h0A;
  localparam logic [7:0] CTL_CR    = 8'h0D;
  localparam logic [7:0] CTL_TAB   = 8'h09;

  typedef enum logic [2:0] {
    MODE_OPEN = 3'd0,
    MODE_TEXT = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_SURR = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       is_quote;
    logic       is_bslash;
    logic       is_u;
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t cls;
    logic      last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       str_end;
    logic       closed;
  } result_t;

  function automatic byte_cls_t classify(input logic [7:0] c);
    byte_cls_t r;
    r.data      = c;
    r.is_quote  = (c == CH_QUOTE);
    r.is_bslash = (c == CH_BSLASH);
    r.is_u      = (c == CH_U);
    r.hex_ok    = 1'b0;
    r.hex_val   = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.hex_ok  = 1'b1;
      r.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.hex_ok  = 1'b1;
      r.hex_val = 4'(c[3:0] + 4'd9);
    end
    return r;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      CH_B:    r = CTL_BS;
      CH_F:    r = CTL_FF;
      CH_N:    r = CTL_LF;
      CH_R:    r = CTL_CR;
      CH_T:    r = CTL_TAB;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
    logic [2:0] r;
    if (cp < 21'h80) begin
      r = 3'd1;
    end else if (cp < 21'h800) begin
      r = 3'd2;
    end else if (cp < 21'h10000) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] idx);
    logic [2:0] len;
    logic [2:0] tail;
    logic [7:0] r;
    len  = utf8_len(cp);
    tail = 3'(len - 3'd1 - {1'b0, idx});
    if (idx == 2'd0) begin
      unique case (len)
        3'd1:    r = cp[7:0];
        3'd2:    r = {3'b110, cp[10:6]};
        3'd3:    r = {4'b1110, cp[15:12]};
        default: r = {5'b11110, cp[20:18]};
      endcase
    end else begin
      unique case (tail)
        3'd0:    r = {2'b10, cp[5:0]};
        3'd1:    r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[17:12]};
      endcase
    end
    return r;
  endfunction

  function automatic result_t byte_res(input logic [7:0] c);
    result_t r;
    r.data    = c;
    r.valid   = 1'b1;
    r.str_end = 1'b0;
    r.closed  = 1'b0;
    return r;
  endfunction

  function automatic result_t end_res(input logic closed);
    result_t r;
    r.data    = 8'h00;
    r.valid   = 1'b0;
    r.str_end = 1'b1;
    r.closed  = closed;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/jsu_front.sv -----
`default_nettype none

module jsu_front
  import jsu_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire [7:0]        in_byte_i,
  input  wire              input_last_i,
  output logic             full_o,
  output logic             item_valid_o,
  output in_item_t         item_o,
  input  wire              take_i
);

  in_item_t          mem_q [INQ_DEPTH];
  logic [INQ_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [INQ_AW:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;
  in_item_t          wr_item;

  assign full_o       = (cnt_q == (INQ_AW+1)'(INQ_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];
  assign do_wr        = push_i && !full_o;
  assign do_rd        = take_i && item_valid_o;

  always_comb begin
    wr_item.cls  = classify(in_byte_i);
    wr_item.last = input_last_i;
    wr_d  = do_wr ? wr_q + INQ_AW'(1) : wr_q;
    rd_d  = do_rd ? rd_q + INQ_AW'(1) : rd_q;
    cnt_d = cnt_q + (INQ_AW+1)'(do_wr) - (INQ_AW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jsu_back.sv -----
`default_nettype none

module jsu_back
  import jsu_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         item_valid_i,
  input  wire in_item_t item_i,
  output logic        item_take_o,
  input  wire         res_full_i,
  output logic        res_push_o,
  output result_t     res_o
);

  mode_e              mode_q, mode_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [15:0]        high_q, high_d;
  logic [15:0]        acc_q, acc_d;
  logic               bad_q, bad_d;
  byte_cls_t          hist_q [HIST_DEPTH];
  logic [HIST_AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic               flush_q, flush_d;
  logic [CP_W-1:0]    emit_cp_q, emit_cp_d;
  logic [2:0]         emit_left_q, emit_left_d;
  logic [1:0]         emit_idx_q, emit_idx_d;

  byte_cls_t          cur;
  logic               consume;
  logic               discard;
  logic [HIST_AW-1:0] rew;
  logic               emit_go;
  logic [CP_W-1:0]    emit_cp;
  logic [15:0]        hex4;
  logic               bad_n;
  logic               surr_fail;

  always_comb begin
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    high_d      = high_q;
    acc_d       = acc_q;
    bad_d       = bad_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    flush_d     = flush_q;
    emit_cp_d   = emit_cp_q;
    emit_left_d = emit_left_q;
    emit_idx_d  = emit_idx_q;
    cur         = hist_q[rp_q];
    consume     = 1'b0;
    discard     = 1'b0;
    rew         = '0;
    emit_go     = 1'b0;
    emit_cp     = '0;
    item_take_o = 1'b0;
    res_push_o  = 1'b0;
    res_o       = end_res(1'b0);

    if (!res_full_i) begin
      if (emit_left_q != 3'd0) begin
        res_push_o  = 1'b1;
        res_o       = byte_res(utf8_byte(emit_cp_q, emit_idx_q));
        emit_idx_d  = emit_idx_q + 2'd1;
        emit_left_d = emit_left_q - 3'd1;
      end else if (wp_q != rp_q) begin
        consume = 1'b1;
      end else if (flush_q) begin
        unique case (mode_q)
          MODE_HEX: begin
            res_push_o = 1'b1;
            res_o      = byte_res(CH_U);
            rp_d       = rp_q - cnt_q[HIST_AW-1:0];
            cnt_d      = '0;
            mode_d     = MODE_TEXT;
          end
          MODE_SURR: begin
            emit_go = 1'b1;
            emit_cp = {5'd0, high_q};
            rp_d    = rp_q - HIST_AW'(cnt_q - HOLD_BS);
            cnt_d   = '0;
            mode_d  = MODE_TEXT;
          end
          default: begin
            res_push_o = 1'b1;
            res_o      = end_res(1'b0);
            cnt_d      = '0;
            mode_d     = MODE_OPEN;
            flush_d    = 1'b0;
          end
        endcase
      end else if (item_valid_i) begin
        consume     = 1'b1;
        cur         = item_i.cls;
        item_take_o = 1'b1;
        wp_d        = wp_q + HIST_AW'(1);
        flush_d     = item_i.last;
      end
    end

    hex4      = {acc_q[11:0], cur.hex_val};
    bad_n     = bad_q | !cur.hex_ok;
    surr_fail = (cnt_q == HOLD_BS && !cur.is_bslash) || (cnt_q == HOLD_U && !cur.is_u) ||
                (cnt_q < HOLD_BS) || (cnt_q >= HOLD_FULL);

    if (consume) begin
      unique case (mode_q)
        MODE_TEXT: begin
          if (cur.is_quote) begin
            res_push_o = 1'b1;
            res_o      = end_res(1'b1);
            mode_d     = MODE_OPEN;
            cnt_d      = '0;
            discard    = 1'b1;
          end else if (cur.is_bslash) begin
            mode_d = MODE_ESC;
          end else begin
            res_push_o = 1'b1;
            res_o      = byte_res(cur.data);
          end
        end
        MODE_ESC: begin
          if (cur.is_u) begin
            mode_d = MODE_HEX;
            cnt_d  = '0;
          end else begin
            res_push_o = 1'b1;
            res_o      = byte_res(escape_map(cur.data));
            mode_d     = MODE_TEXT;
          end
        end
        MODE_HEX: begin
          if (!cur.hex_ok || cnt_q >= HEX_FULL) begin
            res_push_o = 1'b1;
            res_o      = byte_res(CH_U);
            rew        = HIST_AW'(cnt_q) + HIST_AW'(1);
            cnt_d      = '0;
            mode_d     = MODE_TEXT;
          end else begin
            acc_d = hex4;
            cnt_d = cnt_q + CNT_W'(1);
            if (cnt_q == HEX_LAST) begin
              if (hex4 >= SURR_HI_MIN && hex4 <= SURR_HI_MAX) begin
                high_d = hex4;
                mode_d = MODE_SURR;
              end else begin
                emit_go = 1'b1;
                emit_cp = (hex4 >= SURR_LO_MIN && hex4 <= SURR_LO_MAX) ? CP_REPLACE
                                                                      : {5'd0, hex4};
                cnt_d   = '0;
                mode_d  = MODE_TEXT;
              end
            end
          end
        end
        MODE_SURR: begin
          if (surr_fail) begin
            emit_go = 1'b1;
            emit_cp = {5'd0, high_q};
            rew     = (cnt_q >= HOLD_BS) ? HIST_AW'(cnt_q - HOLD_BS) + HIST_AW'(1)
                                         : HIST_AW'(1);
            cnt_d   = '0;
            mode_d  = MODE_TEXT;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
            if (cnt_q >= HOLD_LO0) begin
              acc_d = hex4;
              bad_d = (cnt_q == HOLD_LO0) ? !cur.hex_ok : bad_n;
            end
            if (cnt_q == HOLD_LAST) begin
              emit_go = 1'b1;
              cnt_d   = '0;
              mode_d  = MODE_TEXT;
              if (!bad_n && hex4 >= SURR_LO_MIN && hex4 <= SURR_LO_MAX) begin
                emit_cp = CP_SUPP_BASE + {1'b0, high_q[9:0], hex4[9:0]};
              end else begin
                emit_cp = CP_REPLACE;
                rew     = HIST_AW'(HOLD_FULL - HOLD_BS);
              end
            end
          end
        end
        default: begin
          mode_d = MODE_TEXT;
          cnt_d  = '0;
        end
      endcase
      rp_d = rp_q + HIST_AW'(1) - rew;
      if (discard) begin
        rp_d    = wp_d;
        flush_d = 1'b0;
      end
    end

    if (emit_go) begin
      emit_cp_d   = emit_cp;
      emit_left_d = utf8_len(emit_cp);
      emit_idx_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OPEN;
      cnt_q       <= '0;
      high_q      <= '0;
      acc_q       <= '0;
      bad_q       <= 1'b0;
      wp_q        <= '0;
      rp_q        <= '0;
      flush_q     <= 1'b0;
      emit_cp_q   <= '0;
      emit_left_q <= '0;
      emit_idx_q  <= '0;
    end else begin
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      high_q      <= high_d;
      acc_q       <= acc_d;
      bad_q       <= bad_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      flush_q     <= flush_d;
      emit_cp_q   <= emit_cp_d;
      emit_left_q <= emit_left_d;
      emit_idx_q  <= emit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      hist_q[wp_q] <= item_i.cls;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/jsu_rq.sv -----
`default_nettype none

module jsu_rq
  import jsu_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          push_i,
  input  wire result_t data_i,
  output logic         full_o,
  output logic         empty_o,
  input  wire          pop_i,
  output result_t      data_o
);

  result_t          mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [RQ_AW:0]   cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == (RQ_AW+1)'(RQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_wr ? wr_q + RQ_AW'(1) : wr_q;
    rd_d  = do_rd ? rd_q + RQ_AW'(1) : rd_q;
    cnt_d = cnt_q + (RQ_AW+1)'(do_wr) - (RQ_AW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape.sv -----
`default_nettype none

// Streaming decoder for JSON string literals. Each input request is one byte of text; the
// first byte of a string is taken as its opening quote and dropped unchecked. Decoded bytes
// come out one result per request, and every string finishes with a separate end result
// whose closed_by_quote flag tells a closing quote from the end of input. Escapes, \uXXXX
// to UTF-8 and surrogate pairs are handled; failed lookahead is reprocessed from a small
// history buffer. Ordinary text moves at one byte per cycle while the result queue has
// room. The single decoder handles one byte or one result per cycle while that queue has
// room, so a \u escape takes its input bytes and then, one at a time, the UTF-8 bytes it
// produces; replayed lookahead (at most six bytes) is taken again byte by byte, and the
// end-of-input flush loads each held high surrogate before writing it out raw. Four-entry
// queues sit on both sides; there is no start-up pass after reset.
module json_string_unescape
  import jsu_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push,
  output logic       full,
  input  wire [7:0]  in_byte_i,
  input  wire        input_last_i,
  output logic       empty,
  input  wire        pop,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       string_end_o,
  output logic       closed_by_quote_o
);

  logic     item_valid;
  in_item_t item;
  logic     item_take;
  logic     res_full;
  logic     res_push;
  result_t  res;
  result_t  head;

  jsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_byte_i    (in_byte_i),
    .input_last_i (input_last_i),
    .full_o       (full),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (item_take)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  jsu_rq u_rq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (head)
  );

  assign out_byte_o        = head.data;
  assign byte_valid_o      = head.valid;
  assign string_end_o      = head.str_end;
  assign closed_by_quote_o = head.closed;

endmodule

`default_nettype wire

// ----- verif/jsu_checker.sv -----
`default_nettype none

module jsu_checker
  import jsu_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       push,
  input  wire       full,
  input  wire [7:0] in_byte_i,
  input  wire       input_last_i,
  input  wire       empty,
  input  wire       pop,
  input  wire [7:0] out_byte_i,
  input  wire       byte_valid_i,
  input  wire       string_end_i,
  input  wire       closed_by_quote_i,
  output int        fail_count_o,
  output int        pending_o,
  output int        checked_o
);

  localparam int MAX_RES    = 16;
  localparam int HOLD_N     = 10;
  localparam int WORK_N     = 32;
  localparam int WORK_START = 16;
  localparam int FLUSH_N    = 8;
  localparam int REPORT_N   = 10;

  mode_e       dec_mode = MODE_OPEN;
  logic [7:0]  hold_buf [HOLD_N];
  logic [3:0]  hold_cnt = '0;
  logic [15:0] hi_surr  = '0;

  logic [7:0]  work_buf [WORK_N];
  int          rd_pos;
  int          wr_end;
  bit          closed_now;
  result_t     step_res [$];
  result_t     decoded_q [$];
  result_t     got;
  result_t     want;
  int          errs = 0;
  int          seen = 0;

  function automatic void add_res(logic [7:0] d, logic v, logic e, logic c);
    result_t r;
    r.data    = d;
    r.valid   = v;
    r.str_end = e;
    r.closed  = c;
    if (step_res.size() < MAX_RES) step_res.push_back(r);
  endfunction

  function automatic void emit_cp(logic [CP_W-1:0] cp);
    if (cp < 21'h80) begin
      add_res(cp[7:0], 1'b1, 1'b0, 1'b0);
    end else if (cp < 21'h800) begin
      add_res({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0);
      add_res({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end else if (cp < CP_SUPP_BASE) begin
      add_res({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0);
      add_res({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
      add_res({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end else begin
      add_res({5'b11110, cp[20:18]}, 1'b1, 1'b0, 1'b0);
      add_res({2'b10, cp[17:12]}, 1'b1, 1'b0, 1'b0);
      add_res({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
      add_res({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end
  endfunction

  function automatic logic [4:0] hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'd16;
  endfunction

  function automatic bit quad_at(int from, output logic [15:0] v);
    logic [15:0] acc;
    logic [4:0]  d;
    int          k;
    acc = '0;
    v   = '0;
    for (int i = 0; i < 4; i++) begin
      k = from + i;
      d = (k >= 0 && k < HOLD_N) ? hex_of(hold_buf[k]) : 5'd16;
      if (d > 5'd15) return 1'b0;
      acc = {acc[11:0], d[3:0]};
    end
    v = acc;
    return 1'b1;
  endfunction

  // put held bytes from 'from' (and optionally cur) back at the head of the work buffer
  function automatic void replay_from(int from, bit with_cur, logic [7:0] cur);
    logic [7:0] tmp [HOLD_N+1];
    int         n;
    n = 0;
    for (int i = from; i < int'(hold_cnt) && i < HOLD_N; i++) begin
      tmp[n] = hold_buf[i];
      n++;
    end
    if (with_cur) begin
      tmp[n] = cur;
      n++;
    end
    hold_cnt = '0;
    dec_mode = MODE_TEXT;
    if (n > rd_pos) return;
    rd_pos -= n;
    for (int i = 0; i < n; i++) work_buf[rd_pos+i] = tmp[i];
  endfunction

  function automatic logic [7:0] esc_byte(logic [7:0] e);
    case (e)
      CH_B:    return CTL_BS;
      CH_F:    return CTL_FF;
      CH_N:    return CTL_LF;
      CH_R:    return CTL_CR;
      CH_T:    return CTL_TAB;
      default: return e;
    endcase
  endfunction

  function automatic void take_byte(logic [7:0] b);
    logic [15:0]     v;
    logic [CP_W-1:0] cp;
    v = '0;
    case (dec_mode)
      MODE_TEXT: begin
        if (b == CH_QUOTE) begin
          add_res(8'h00, 1'b0, 1'b1, 1'b1);
          dec_mode   = MODE_OPEN;
          hold_cnt   = '0;
          closed_now = 1'b1;
        end else if (b == CH_BSLASH) begin
          dec_mode = MODE_ESC;
        end else begin
          add_res(b, 1'b1, 1'b0, 1'b0);
        end
      end
      MODE_ESC: begin
        if (b == CH_U) begin
          dec_mode = MODE_HEX;
          hold_cnt = '0;
        end else begin
          add_res(esc_byte(b), 1'b1, 1'b0, 1'b0);
          dec_mode = MODE_TEXT;
        end
      end
      MODE_HEX: begin
        if (hex_of(b) > 5'd15 || hold_cnt >= HEX_FULL) begin
          add_res(CH_U, 1'b1, 1'b0, 1'b0);
          replay_from(0, 1'b1, b);
        end else begin
          hold_buf[hold_cnt] = b;
          hold_cnt++;
          if (hold_cnt == HEX_FULL && quad_at(0, v)) begin
            if (v >= SURR_HI_MIN && v <= SURR_HI_MAX) begin
              hi_surr  = v;
              dec_mode = MODE_SURR;
            end else begin
              emit_cp((v >= SURR_LO_MIN && v <= SURR_LO_MAX) ? CP_REPLACE : CP_W'(v));
              hold_cnt = '0;
              dec_mode = MODE_TEXT;
            end
          end
        end
      end
      MODE_SURR: begin
        if ((hold_cnt == HOLD_BS && b != CH_BSLASH) || (hold_cnt == HOLD_U && b != CH_U) ||
            hold_cnt < HOLD_BS || hold_cnt >= HOLD_FULL) begin
          emit_cp(CP_W'(hi_surr));
          replay_from(4, 1'b1, b);
        end else begin
          hold_buf[hold_cnt] = b;
          hold_cnt++;
          if (hold_cnt == HOLD_FULL) begin
            if (quad_at(6, v) && v >= SURR_LO_MIN && v <= SURR_LO_MAX) begin
              cp = CP_SUPP_BASE + (CP_W'(hi_surr - SURR_HI_MIN) << 10) +
                   CP_W'(v - SURR_LO_MIN);
              emit_cp(cp);
              hold_cnt = '0;
              dec_mode = MODE_TEXT;
            end else begin
              emit_cp(CP_REPLACE);
              replay_from(4, 1'b0, 8'h00);
            end
          end
        end
      end
      default: begin
        dec_mode = MODE_TEXT;
        hold_cnt = '0;
      end
    endcase
  endfunction

  function automatic void drain_work();
    logic [7:0] b;
    while (rd_pos < wr_end && !closed_now) begin
      b = work_buf[rd_pos];
      rd_pos++;
      take_byte(b);
    end
    if (closed_now) rd_pos = wr_end;
  endfunction

  function automatic void decode_request(logic [7:0] b, logic last);
    step_res.delete();
    closed_now         = 1'b0;
    rd_pos             = WORK_START;
    wr_end             = WORK_START + 1;
    work_buf[WORK_START] = b;
    drain_work();
    if (last && !closed_now) begin
      for (int g = 0; g < FLUSH_N && !closed_now; g++) begin
        if (dec_mode == MODE_HEX) begin
          add_res(CH_U, 1'b1, 1'b0, 1'b0);
          replay_from(0, 1'b0, 8'h00);
        end else if (dec_mode == MODE_SURR) begin
          emit_cp(CP_W'(hi_surr));
          replay_from(4, 1'b0, 8'h00);
        end else begin
          add_res(8'h00, 1'b0, 1'b1, 1'b0);
          dec_mode = MODE_OPEN;
          hold_cnt = '0;
          break;
        end
        drain_work();
      end
    end
    foreach (step_res[i]) decoded_q.push_back(step_res[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_mode = MODE_OPEN;
      hold_cnt = '0;
      hi_surr  = '0;
      foreach (hold_buf[i]) hold_buf[i] = '0;
      decoded_q.delete();
      errs = 0;
      seen = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (pop && !empty) begin
        got.data    = out_byte_i;
        got.valid   = byte_valid_i;
        got.str_end = string_end_i;
        got.closed  = closed_by_quote_i;
        seen++;
        if (decoded_q.size() == 0) begin
          if (errs < REPORT_N)
            $display("unexpected result at %0t: byte %02h valid %b end %b closed %b",
                     $realtime, got.data, got.valid, got.str_end, got.closed);
          errs++;
        end else begin
          want = decoded_q.pop_front();
          if (got.data !== want.data || got.valid !== want.valid ||
              got.str_end !== want.str_end || got.closed !== want.closed) begin
            if (errs < REPORT_N) begin
              $display("mismatch at %0t: expected byte %02h valid %b end %b closed %b",
                       $realtime, want.data, want.valid, want.str_end, want.closed);
              $display("  got byte %02h valid %b end %b closed %b",
                       got.data, got.valid, got.str_end, got.closed);
            end
            errs++;
          end
        end
      end
      if (push && !full) decode_request(in_byte_i, input_last_i);
      fail_count_o <= errs;
      pending_o    <= decoded_q.size();
      checked_o    <= seen;
    end
  end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
  import jsu_pkg::*;

  localparam int ITEMS       = 460;
  localparam int CALM_AT     = 400;
  localparam int DRAIN_LIMIT = 100000;
  localparam int TAIL_CYCLES = 100;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] in_byte_i;
  logic       input_last_i;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       string_end_o;
  logic       closed_by_quote_o;

  int         fail_count;
  int         pending;
  int         checked;
  int         sent    = 0;
  int         strings = 0;
  bit         calm    = 1'b0;
  logic [7:0] text_q [$];

  json_string_unescape i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .in_byte_i         (in_byte_i),
    .input_last_i      (input_last_i),
    .empty             (empty),
    .pop               (pop),
    .out_byte_o        (out_byte_o),
    .byte_valid_o      (byte_valid_o),
    .string_end_o      (string_end_o),
    .closed_by_quote_o (closed_by_quote_o)
  );

  jsu_checker i_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .in_byte_i         (in_byte_i),
    .input_last_i      (input_last_i),
    .empty             (empty),
    .pop               (pop),
    .out_byte_i        (out_byte_o),
    .byte_valid_i      (byte_valid_o),
    .string_end_i      (string_end_o),
    .closed_by_quote_i (closed_by_quote_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .checked_o         (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #6000000;
    $display("timeout: %0d input bytes sent, %0d results pending", sent, pending);
    $display("status: fail");
    $finish;
  end

  // result side: random stall bursts until the last part of the run
  initial begin
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    push         <= 1'b1;
    in_byte_i    <= b;
    input_last_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_text(logic last_end);
    foreach (text_q[i]) send_byte(text_q[i], last_end && (i == text_q.size() - 1));
    text_q.delete();
    strings++;
  endtask

  // hold off the sender until every expected result has come out
  task automatic drain_pause();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return 8'("0" + d);
    if ($urandom_range(0, 1) == 1) return 8'("a" + d - 8'd10);
    return 8'("A" + d - 8'd10);
  endfunction

  function automatic void put_uesc(logic [15:0] v);
    text_q.push_back(CH_BSLASH);
    text_q.push_back(CH_U);
    for (int i = 3; i >= 0; i--) text_q.push_back(hex_char(v[4*i +: 4]));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
    return b;
  endfunction

  function automatic logic [15:0] rand_bmp();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(16'h0000, 16'h007F));
      1:       return 16'($urandom_range(16'h0080, 16'h07FF));
      2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
      default: return 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'($urandom_range(SURR_HI_MIN, SURR_HI_MAX));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'($urandom_range(SURR_LO_MIN, SURR_LO_MAX));
  endfunction

  function automatic void add_piece();
    logic [7:0] esc_set [8] = '{CH_QUOTE, CH_BSLASH, 8'h2F, CH_B, CH_F, CH_N, CH_R, CH_T};
    logic [7:0] b;
    int         k;
    case ($urandom_range(0, 9))
      0, 1: repeat ($urandom_range(1, 4)) text_q.push_back(plain_byte());
      2: begin
        text_q.push_back(CH_BSLASH);
        if ($urandom_range(0, 3) == 0) text_q.push_back(8'($urandom_range(0, 255)));
        else text_q.push_back(esc_set[$urandom_range(0, 7)]);
      end
      3: put_uesc(rand_bmp());
      4: begin
        put_uesc(rand_high());
        put_uesc(rand_low());
      end
      5: put_uesc(rand_low());
      6: begin
        put_uesc(rand_high());
        if ($urandom_range(0, 1) == 1) begin
          text_q.push_back(plain_byte());
        end else begin
          text_q.push_back(CH_BSLASH);
          do b = 8'($urandom_range(0, 255)); while (b == CH_U);
          text_q.push_back(b);
        end
      end
      7: begin
        put_uesc(rand_high());
        case ($urandom_range(0, 2))
          0: put_uesc(rand_high());
          1: put_uesc(rand_bmp());
          default: begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(CH_U);
            k = $urandom_range(0, 7);
            for (int i = 0; i < 4; i++)
              text_q.push_back((i == k) ? CH_QUOTE : 8'($urandom_range(0, 255)));
          end
        endcase
      end
      8: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        repeat ($urandom_range(0, 3)) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        text_q.push_back(non_hex_byte());
      end
      default: put_uesc(rand_high());
    endcase
  endfunction

  // build one string; returns whether its final byte carries input_last
  function automatic logic build_string();
    int k;
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 5)) add_piece();
    k = $urandom_range(0, 9);
    if (k <= 6) begin
      text_q.push_back(CH_QUOTE);
      return ($urandom_range(0, 7) == 0);
    end
    if (k == 7) return 1'b1;
    case ($urandom_range(0, 2))
      0: text_q.push_back(CH_BSLASH);
      1: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_U);
        repeat ($urandom_range(0, 3)) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
      default: begin
        put_uesc(rand_high());
        k = $urandom_range(0, 5);
        if (k > 0) text_q.push_back(CH_BSLASH);
        if (k > 1) text_q.push_back(CH_U);
        repeat ((k > 2) ? k - 2 : 0) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
      end
    endcase
    return 1'b1;
  endfunction

  initial begin
    logic last_end;
    rst_ni       = 1'b0;
    push         = 1'b0;
    in_byte_i    = 8'h00;
    input_last_i = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    text_q = {CH_QUOTE, 8'h00, 8'hFF, CH_BSLASH, CH_U, "0", "0", "0", "0", CH_QUOTE};
    send_text(1'b0);
    text_q = {CH_QUOTE, CH_BSLASH, CH_U, "D", "C", "0", "0", CH_BSLASH, CH_U, "1", CH_QUOTE};
    send_text(1'b0);
    text_q = {CH_QUOTE};
    send_text(1'b1);
    text_q = {CH_QUOTE, CH_BSLASH};
    send_text(1'b1);
    drain_pause();

    while (sent < ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        last_end = build_string();
        send_text(last_end);
      end
      if (!calm && strings % 9 == 4) drain_pause();
      if (sent >= CALM_AT) calm = 1'b1;
    end
    push <= 1'b0;
    @(posedge clk_i);

    for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("decoded %0d input bytes over %0d strings and noise; %0d results checked",
             sent, strings, checked);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
